>>> sv/tpbd_pkg.sv
// ---------------------------------------------------------------------------
// tpbd_pkg: shared types and constants of the tape pulse block decoder
// Pulse classes, register indexes, reset values and the record that passes
// from the classifying front end to the bit assembler.
// ---------------------------------------------------------------------------
`default_nettype none

package tpbd_pkg;

  // Pulse classes
  typedef enum logic [1:0] {
    CLS_SHORT  = 2'd0,
    CLS_MEDIUM = 2'd1,
    CLS_LONG   = 2'd2,
    CLS_PAUSE  = 2'd3
  } pulse_class_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FORMAT_VERSION   = 2'd0,
    REG_SHORT_THRESHOLD  = 2'd1,
    REG_MEDIUM_THRESHOLD = 2'd2,
    REG_MAX_BLOCK_BYTES  = 2'd3
  } reg_index_t;

  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic [1:0]  RST_FORMAT_VERSION   = 2'd1;
  localparam logic [7:0]  RST_SHORT_THRESHOLD  = 8'd54;
  localparam logic [7:0]  RST_MEDIUM_THRESHOLD = 8'd74;
  localparam logic [15:0] RST_MAX_BLOCK_BYTES  = 16'hFFFF;

  // Pulses at or above this many cycles are pauses
  localparam logic [23:0] PAUSE_BOUND = 24'h001000;
  // Marker byte that opens a four-byte long pulse
  localparam logic [7:0]  LONG_MARKER = 8'h00;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [1:0]  format_version;
    logic [7:0]  short_threshold;
    logic [7:0]  medium_threshold;
    logic [15:0] max_block_bytes;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic         block_start;
    logic         last_byte;
    logic         pulse_valid;
    pulse_class_t pulse_class;
    logic [23:0]  pulse_len;
  } item_t;

endpackage

`default_nettype wire

>>> sv/tpbd_front.sv
// ---------------------------------------------------------------------------
// tpbd_front: pulse assembly and classification
// Gathers long pulses from marker plus three count bytes, turns plain bytes
// into cycle counts and classes each completed pulse.
// ---------------------------------------------------------------------------
`default_nettype none

module tpbd_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tpbd_pkg::cfg_t     cfg,
  input  wire logic               take,
  input  wire logic [7:0]         pulse_byte,
  input  wire logic               block_start,
  input  wire logic               last_byte,
  output tpbd_pkg::item_t         item
);

  logic [1:0]  long_phase;
  logic [23:0] long_value;
  logic [1:0]  long_phase_next;
  logic [23:0] long_value_next;

  logic [1:0]  ph;
  logic [23:0] val;
  logic [23:0] gathered;
  logic        pv;
  logic [23:0] cycles;
  tpbd_pkg::pulse_class_t cls;

  // Long pulse gathering; a block start drops any partial count
  always_comb begin
    ph              = block_start ? 2'd0 : long_phase;
    val             = block_start ? 24'd0 : long_value;
    gathered        = val;
    pv              = 1'b0;
    cycles          = 24'd0;
    long_phase_next = ph;
    long_value_next = val;
    case (ph)
      2'd1:    gathered = val | {16'd0, pulse_byte};
      2'd2:    gathered = val | {8'd0, pulse_byte, 8'd0};
      2'd3:    gathered = val | {pulse_byte, 16'd0};
      default: gathered = val;
    endcase
    if (ph != 2'd0) begin
      if (ph == 2'd3) begin
        cycles          = gathered;
        pv              = 1'b1;
        long_phase_next = 2'd0;
        long_value_next = 24'd0;
      end else begin
        long_phase_next = ph + 2'd1;
        long_value_next = gathered;
      end
    end else if (pulse_byte == tpbd_pkg::LONG_MARKER && cfg.format_version != 2'd0) begin
      long_phase_next = 2'd1;
      long_value_next = 24'd0;
    end else begin
      cycles = {13'd0, pulse_byte, 3'd0};
      pv     = 1'b1;
    end
  end

  // Classification against the thresholds (each threshold register scaled by eight)
  always_comb begin
    if (!pv) begin
      cls = tpbd_pkg::CLS_SHORT;
    end else if (cycles < {13'd0, cfg.short_threshold, 3'd0}) begin
      cls = tpbd_pkg::CLS_SHORT;
    end else if (cycles < {13'd0, cfg.medium_threshold, 3'd0}) begin
      cls = tpbd_pkg::CLS_MEDIUM;
    end else if (cycles < tpbd_pkg::PAUSE_BOUND) begin
      cls = tpbd_pkg::CLS_LONG;
    end else begin
      cls = tpbd_pkg::CLS_PAUSE;
    end
  end

  always_comb begin
    item.block_start = block_start;
    item.last_byte   = last_byte;
    item.pulse_valid = pv;
    item.pulse_class = cls;
    item.pulse_len   = cycles;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_phase <= 2'd0;
      long_value <= 24'd0;
    end else if (take) begin
      long_phase <= long_phase_next;
      long_value <= long_value_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/tpbd_queue.sv
// ---------------------------------------------------------------------------
// tpbd_queue: small FIFO of classified items
// Decouples the front end from the bit assembler so each can stall alone.
// ---------------------------------------------------------------------------
`default_nettype none

module tpbd_queue #(
  parameter int unsigned DEPTH = tpbd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire tpbd_pkg::item_t   wr_item,
  output logic                   full,
  input  wire logic              pop,
  output logic                   not_empty,
  output tpbd_pkg::item_t        rd_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tpbd_pkg::item_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_item   = mem[rd_ptr];

  // Storage write
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/tpbd_back.sv
// ---------------------------------------------------------------------------
// tpbd_back: bit assembly and block control
// Shifts short/medium pulses into bytes, counts bytes, ends the block and
// holds the result in an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tpbd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tpbd_pkg::cfg_t    cfg,
  input  wire logic              q_valid,
  input  wire tpbd_pkg::item_t   q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   byte_valid,
  output logic [7:0]             data_byte,
  output logic [15:0]            bytes_so_far,
  output logic                   pulse_valid,
  output logic [1:0]             pulse_class,
  output logic [23:0]            pulse_len,
  output logic                   block_done
);

  logic [7:0]  bit_shift;
  logic [2:0]  bit_cnt;
  logic [15:0] byte_count;
  logic        stopped;

  logic [7:0]  bit_shift_next;
  logic [2:0]  bit_cnt_next;
  logic [15:0] byte_count_next;
  logic        stopped_next;

  logic [7:0]  sh;
  logic [2:0]  cnt;
  logic [15:0] bc;
  logic        stp;
  logic        bv;
  logic [7:0]  data;
  logic        pv;
  logic [1:0]  cls;
  logic [23:0] cyc;
  logic        done;
  logic        is_bit;

  // Take a new item whenever the output register is free or drains
  assign q_pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    sh  = q_item.block_start ? 8'd0  : bit_shift;
    cnt = q_item.block_start ? 3'd0  : bit_cnt;
    bc  = q_item.block_start ? 16'd0 : byte_count;
    stp = q_item.block_start ? 1'b0  : stopped;

    bit_shift_next  = sh;
    bit_cnt_next    = cnt;
    byte_count_next = bc;
    stopped_next    = stp;
    bv     = 1'b0;
    data   = 8'd0;
    pv     = 1'b0;
    cls    = 2'd0;
    cyc    = 24'd0;
    done   = 1'b0;
    is_bit = (q_item.pulse_class == tpbd_pkg::CLS_SHORT) ||
             (q_item.pulse_class == tpbd_pkg::CLS_MEDIUM);

    if (stp) begin
      done = 1'b1;
    end else if (bc >= cfg.max_block_bytes) begin
      done = 1'b1;
    end else begin
      if (q_item.pulse_valid) begin
        pv  = 1'b1;
        cls = q_item.pulse_class;
        cyc = q_item.pulse_len;
        if (is_bit) begin
          // first bit received ends up most significant
          bit_shift_next = {sh[6:0], q_item.pulse_class == tpbd_pkg::CLS_MEDIUM};
          bit_cnt_next   = cnt + 3'd1;
          if (bit_cnt_next == 3'd0) begin
            bv             = 1'b1;
            data           = bit_shift_next;
            bit_shift_next = 8'd0;
          end
        end else begin
          // long pulse or pause flushes a partial byte
          if (cnt != 3'd0) begin
            bv             = 1'b1;
            data           = sh;
            bit_shift_next = 8'd0;
            bit_cnt_next   = 3'd0;
          end
          if (q_item.pulse_class == tpbd_pkg::CLS_PAUSE) begin
            done = 1'b1;
          end
        end
        if (bv) begin
          byte_count_next = bc + 16'd1;
          if (byte_count_next >= cfg.max_block_bytes) begin
            done = 1'b1;
          end
        end
      end
      if (q_item.last_byte) begin
        done = 1'b1;
      end
    end

    // end of block drops held bits
    if (done) begin
      stopped_next   = 1'b1;
      bit_shift_next = 8'd0;
      bit_cnt_next   = 3'd0;
    end
  end

  // Block state
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_shift  <= 8'd0;
      bit_cnt    <= 3'd0;
      byte_count <= 16'd0;
      stopped    <= 1'b0;
    end else if (q_pop) begin
      bit_shift  <= bit_shift_next;
      bit_cnt    <= bit_cnt_next;
      byte_count <= byte_count_next;
      stopped    <= stopped_next;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      byte_valid   <= bv;
      data_byte    <= data;
      bytes_so_far <= byte_count_next;
      pulse_valid  <= pv;
      pulse_class  <= cls;
      pulse_len    <= cyc;
      block_done   <= done;
    end
  end

endmodule

`default_nettype wire

>>> sv/tape_pulse_block_decoder_unit.sv
// ---------------------------------------------------------------------------
// tape_pulse_block_decoder_unit: tape pulse block decoder, top level
// Decodes raw tape-image pulse bytes into data bytes, one result per byte.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one raw pulse byte with its
//   block_start and last_byte flags per transfer. Output channel
//   (out_valid / out_stall) carries exactly one result per input byte, in
//   order: decoded byte, byte count, completed pulse and its class, and the
//   block-done flag.
//   Throughput: one byte per cycle while out_stall is low. The front end
//   assembles and classes a pulse in the cycle of the transfer and writes it
//   to a small queue; the back end pops one entry per cycle into the output
//   register whenever that register is free or drains.
//   When the receiver stalls, the output register holds its result, the
//   queue fills, and in_stall rises once the queue is full; no item is lost.
//   Reset clears the decoder state and the queue and loads the register
//   defaults (version 1, thresholds 54 and 74, byte limit 65535).
//   Registers are written through wr_en / wr_index / wr_data; the user must
//   write them only while idle, as the block itself does not enforce it.
// ---------------------------------------------------------------------------
`default_nettype none

module tape_pulse_block_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = tpbd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [1:0]                    wr_index,
  input  wire logic [tpbd_pkg::CFG_DATA_W-1:0] wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    pulse_byte,
  input  wire logic                          block_start,
  input  wire logic                          last_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               byte_valid,
  output logic [7:0]                         data_byte,
  output logic [15:0]                        bytes_so_far,
  output logic                               pulse_valid,
  output logic [1:0]                         pulse_class,
  output logic [23:0]                        pulse_len,
  output logic                               block_done
);

  tpbd_pkg::cfg_t  cfg;
  tpbd_pkg::item_t front_item;
  tpbd_pkg::item_t q_item;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  logic            take;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.format_version   <= tpbd_pkg::RST_FORMAT_VERSION;
      cfg.short_threshold  <= tpbd_pkg::RST_SHORT_THRESHOLD;
      cfg.medium_threshold <= tpbd_pkg::RST_MEDIUM_THRESHOLD;
      cfg.max_block_bytes  <= tpbd_pkg::RST_MAX_BLOCK_BYTES;
    end else if (wr_en) begin
      case (tpbd_pkg::reg_index_t'(wr_index))
        tpbd_pkg::REG_FORMAT_VERSION:   cfg.format_version   <= wr_data[1:0];
        tpbd_pkg::REG_SHORT_THRESHOLD:  cfg.short_threshold  <= wr_data[7:0];
        tpbd_pkg::REG_MEDIUM_THRESHOLD: cfg.medium_threshold <= wr_data[7:0];
        tpbd_pkg::REG_MAX_BLOCK_BYTES:  cfg.max_block_bytes  <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  tpbd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .take        (take),
    .pulse_byte  (pulse_byte),
    .block_start (block_start),
    .last_byte   (last_byte),
    .item        (front_item)
  );

  tpbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .wr_item   (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rd_item   (q_item)
  );

  tpbd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_valid   (byte_valid),
    .data_byte    (data_byte),
    .bytes_so_far (bytes_so_far),
    .pulse_valid  (pulse_valid),
    .pulse_class  (pulse_class),
    .pulse_len    (pulse_len),
    .block_done   (block_done)
  );

endmodule

`default_nettype wire

>>> sv/tpbd_check.sv
// ---------------------------------------------------------------------------
// tpbd_check: port-level checks of the tape pulse block decoder
// Watches the result channel for consistency of the decoded fields.
// ---------------------------------------------------------------------------
`default_nettype none

module tpbd_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        byte_valid,
  input wire logic [7:0]  data_byte,
  input wire logic        pulse_valid,
  input wire logic [1:0]  pulse_class,
  input wire logic [23:0] pulse_len,
  input wire logic        block_done
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(block_done))
    else $error("stalled result changed");

  // no data without a byte
  a_no_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> data_byte == 8'd0)
    else $error("data_byte set without byte_valid");

  // no pulse fields without a pulse
  a_no_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pulse_valid |-> pulse_class == 2'd0 && pulse_len == 24'd0)
    else $error("pulse fields set without pulse_valid");

  // a pause always ends the block
  a_pause_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && pulse_valid && pulse_class == 2'd3 |-> block_done)
    else $error("pause without block_done");

  // data bits come only from pulses under the pause bound
  a_bit_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && pulse_valid && (pulse_class == 2'd0 || pulse_class == 2'd1)
      |-> pulse_len < 24'h001000)
    else $error("bit pulse at or above pause bound");

endmodule

bind tape_pulse_block_decoder_unit tpbd_check u_tpbd_check (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .byte_valid   (byte_valid),
  .data_byte    (data_byte),
  .pulse_valid  (pulse_valid),
  .pulse_class  (pulse_class),
  .pulse_len    (pulse_len),
  .block_done   (block_done)
);

`default_nettype wire

>>> verif/tape_pulse_block_decoder_unit_test.sv
// ---------------------------------------------------------------------------
// tape_pulse_block_decoder_unit_test: self-checking bench for the decoder
// Streams raw pulse bytes through the block under a series of register
// settings and idle patterns. A scoreboard class predicts the decoded result
// of each input transfer and checks every output transfer against it in order.
// ---------------------------------------------------------------------------

module tape_pulse_block_decoder_unit_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 80;

  // Expected-result store and bit-level decode predictor
  class tpbd_scoreboard;
    typedef struct {
      logic                   bv;
      logic [7:0]             data;
      logic [15:0]            count;
      logic                   pv;
      tpbd_pkg::pulse_class_t cls;
      logic [23:0]            cycles;
      logic                   done;
    } decode_t;

    decode_t     expected_q[$];
    // register copies
    logic [1:0]  version;
    logic [7:0]  short_thr;
    logic [7:0]  medium_thr;
    logic [15:0] byte_limit;
    // decoder state
    logic [1:0]  long_step;
    logic [23:0] long_acc;
    logic [7:0]  shift_reg;
    logic [2:0]  bits_held;
    logic [15:0] bytes_done;
    logic        ended;
    // tallies
    int errors;
    int n_inputs;
    int n_results;
    int n_data;
    int n_pauses;
    int n_ends;

    function new();
      version    = tpbd_pkg::RST_FORMAT_VERSION;
      short_thr  = tpbd_pkg::RST_SHORT_THRESHOLD;
      medium_thr = tpbd_pkg::RST_MEDIUM_THRESHOLD;
      byte_limit = tpbd_pkg::RST_MAX_BLOCK_BYTES;
      clear_block();
      errors = 0; n_inputs = 0; n_results = 0;
      n_data = 0; n_pauses = 0; n_ends = 0;
    endfunction

    function void clear_block();
      long_step  = '0;
      long_acc   = '0;
      shift_reg  = '0;
      bits_held  = '0;
      bytes_done = '0;
      ended      = 1'b0;
    endfunction

    // held bits are dropped, count is kept
    function void end_block();
      ended     = 1'b1;
      long_step = '0;
      long_acc  = '0;
      shift_reg = '0;
      bits_held = '0;
    endfunction

    function tpbd_pkg::pulse_class_t classify(logic [23:0] cyc);
      int unsigned c;
      c = 32'(cyc);
      if (c < 32'(short_thr) * 8) return tpbd_pkg::CLS_SHORT;
      if (c < 32'(medium_thr) * 8) return tpbd_pkg::CLS_MEDIUM;
      if (c < 32'(tpbd_pkg::PAUSE_BOUND)) return tpbd_pkg::CLS_LONG;
      return tpbd_pkg::CLS_PAUSE;
    endfunction

    function void write_reg(tpbd_pkg::reg_index_t idx, logic [15:0] val);
      case (idx)
        tpbd_pkg::REG_FORMAT_VERSION:   version = val[1:0];
        tpbd_pkg::REG_SHORT_THRESHOLD:  short_thr = val[7:0];
        tpbd_pkg::REG_MEDIUM_THRESHOLD: medium_thr = val[7:0];
        tpbd_pkg::REG_MAX_BLOCK_BYTES:  byte_limit = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Predict the result of one accepted input transfer
    function void note_input(logic [7:0] pb, logic start, logic last);
      decode_t r;
      r.bv = 1'b0; r.data = '0; r.pv = 1'b0;
      r.cls = tpbd_pkg::CLS_SHORT; r.cycles = '0; r.done = 1'b0;
      if (start) clear_block();
      if (ended) begin
        r.done = 1'b1;
      end else if (bytes_done >= byte_limit) begin
        end_block();
        r.done = 1'b1;
      end else begin
        // pulse assembly: long form gathers three count bytes
        if (long_step != 0) begin
          long_acc = long_acc | (24'(pb) << (8 * (long_step - 1)));
          if (long_step == 2'd3) begin
            r.cycles  = long_acc;
            r.pv      = 1'b1;
            long_step = '0;
            long_acc  = '0;
          end else begin
            long_step = long_step + 2'd1;
          end
        end else if (pb == tpbd_pkg::LONG_MARKER && version >= 2'd1) begin
          long_step = 2'd1;
          long_acc  = '0;
        end else begin
          r.cycles = 24'(pb) << 3;
          r.pv     = 1'b1;
        end
        // bit assembly
        if (r.pv) begin
          r.cls = classify(r.cycles);
          if (r.cls == tpbd_pkg::CLS_SHORT || r.cls == tpbd_pkg::CLS_MEDIUM) begin
            shift_reg = {shift_reg[6:0], r.cls == tpbd_pkg::CLS_MEDIUM};
            bits_held = bits_held + 3'd1;
            if (bits_held == 3'd0) begin
              r.bv = 1'b1; r.data = shift_reg; shift_reg = '0;
            end
          end else begin
            if (bits_held != 3'd0) begin
              r.bv = 1'b1; r.data = shift_reg; shift_reg = '0; bits_held = '0;
            end
            if (r.cls == tpbd_pkg::CLS_PAUSE) r.done = 1'b1;
          end
          if (r.bv) begin
            bytes_done = bytes_done + 16'd1;
            if (bytes_done >= byte_limit) r.done = 1'b1;
          end
        end
        if (last) r.done = 1'b1;
        if (r.done) end_block();
        if (r.done) n_ends++;
      end
      r.count = bytes_done;
      n_inputs++;
      if (r.bv) n_data++;
      if (r.pv && r.cls == tpbd_pkg::CLS_PAUSE) n_pauses++;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Compare one output transfer against the oldest expectation
    task check_result(logic bv, logic [7:0] data, logic [15:0] count, logic pv,
                      logic [1:0] cls, logic [23:0] cycles, logic done);
      decode_t e;
      n_results++;
      if (expected_q.size() == 0) begin
        report("output transfer with no result expected");
        return;
      end
      e = expected_q.pop_front();
      if (bv !== e.bv)
        report($sformatf("byte_valid got %0b want %0b", bv, e.bv));
      if (data !== e.data)
        report($sformatf("data_byte got %0h want %0h", data, e.data));
      if (count !== e.count)
        report($sformatf("bytes_so_far got %0d want %0d", count, e.count));
      if (pv !== e.pv)
        report($sformatf("pulse_valid got %0b want %0b", pv, e.pv));
      if (cls !== e.cls)
        report($sformatf("pulse_class got %0d want %0d", cls, e.cls));
      if (cycles !== e.cycles)
        report($sformatf("pulse_len got %0h want %0h", cycles, e.cycles));
      if (done !== e.done)
        report($sformatf("block_done got %0b want %0b", done, e.done));
    endtask
  endclass

  typedef struct {
    logic [7:0] pb;
    logic       start;
    logic       last;
  } raw_item_t;

  // DUT ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = '0;
  logic [15:0] wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  pulse_byte = '0;
  logic        block_start = 1'b0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        byte_valid;
  logic [7:0]  data_byte;
  logic [15:0] bytes_so_far;
  logic        pulse_valid;
  logic [1:0]  pulse_class;
  logic [23:0] pulse_len;
  logic        block_done;

  tpbd_scoreboard sb;
  raw_item_t      block_q[$];
  logic           next_start = 1'b0;
  int cur_version = tpbd_pkg::RST_FORMAT_VERSION;
  int cur_st      = tpbd_pkg::RST_SHORT_THRESHOLD;
  int cur_mt      = tpbd_pkg::RST_MEDIUM_THRESHOLD;
  int send_idle   = 0;
  int recv_idle   = 0;
  int hold_seq    = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int n_phases    = 0;

  tape_pulse_block_decoder_unit dut (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pulse_byte   (pulse_byte),
    .block_start  (block_start),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_valid   (byte_valid),
    .data_byte    (data_byte),
    .bytes_so_far (bytes_so_far),
    .pulse_valid  (pulse_valid),
    .pulse_class  (pulse_class),
    .pulse_len    (pulse_len),
    .block_done   (block_done)
  );

  always #6 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !rst && ($urandom_range(99) < recv_idle);
    end
  end

  // Monitor both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_result(byte_valid, data_byte, bytes_so_far, pulse_valid,
                        pulse_class, pulse_len, block_done);
      if (in_valid && !in_stall)
        sb.note_input(pulse_byte, block_start, last_byte);
    end
  end

  // Watchdog: too long with no transfer on either channel
  initial begin
    int quiet;
    quiet = 0;
    wait (!rst);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic push_raw(logic [7:0] pb, logic s, logic l);
    raw_item_t it;
    it.pb = pb; it.start = s; it.last = l;
    block_q.push_back(it);
  endtask

  // Random item within a block; a stray start or last now and then
  task automatic add_byte(logic [7:0] pb);
    raw_item_t it;
    it.pb    = pb;
    it.start = next_start || ($urandom_range(199) == 0);
    it.last  = ($urandom_range(99) < 2);
    next_start = 1'b0;
    block_q.push_back(it);
  endtask

  task automatic add_long(logic [23:0] v);
    add_byte(tpbd_pkg::LONG_MARKER);
    add_byte(v[7:0]);
    add_byte(v[15:8]);
    add_byte(v[23:16]);
  endtask

  // One well-formed block with random content, ended various ways
  task automatic build_block();
    int n;
    int r;
    int lo0;
    int lo_med;
    int lo_long;
    logic [23:0] v;
    n = ($urandom_range(9) == 0) ? $urandom_range(80, 25) : $urandom_range(24, 1);
    next_start = ($urandom_range(99) < 92);
    lo0 = (cur_version == 0) ? 0 : 1;
    lo_med = (cur_st > lo0) ? cur_st : lo0;
    lo_long = (cur_st > cur_mt) ? cur_st : cur_mt;
    if (lo_long < 1) lo_long = 1;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 40 && cur_st > lo0) begin
        add_byte(8'($urandom_range(cur_st - 1, lo0)));
      end else if (r < 80 && cur_mt > lo_med) begin
        add_byte(8'($urandom_range(cur_mt - 1, lo_med)));
      end else if (r < 86 && lo_long <= 255) begin
        add_byte(8'($urandom_range(255, lo_long)));
      end else if (r < 94 && cur_version != 0) begin
        case ($urandom_range(3))
          0: v = 24'($urandom_range(24'hFFF, 0));
          1: v = 24'($urandom);
          2: v = 24'h000FFF + 24'($urandom_range(1));
          default: v = 24'($urandom_range(cur_st * 8 + 8, 0));
        endcase
        add_long(v);
      end else begin
        add_byte(8'($urandom_range(255, 0)));
      end
    end
    r = $urandom_range(99);
    if (r < 35 && cur_version != 0)
      add_long(24'($urandom_range(24'hFFFFFF, 24'h001000)));
    else if (r < 65)
      block_q[block_q.size() - 1].last = 1'b1;
  endtask

  // Offer queued items one transfer at a time
  task automatic send_queue();
    raw_item_t it;
    while (block_q.size() != 0) begin
      it = block_q.pop_front();
      while ($urandom_range(99) < send_idle) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid    <= 1'b1;
      pulse_byte  <= it.pb;
      block_start <= it.start;
      last_byte   <= it.last;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
  endtask

  // Wait until every expected result has arrived
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(tpbd_pkg::reg_index_t idx, logic [15:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // Narrow registers get junk in the unused upper bits of the write data
  task automatic set_config(int ver, int st, int mt, int lim);
    put_reg(tpbd_pkg::REG_FORMAT_VERSION, {14'($urandom), 2'(ver)});
    put_reg(tpbd_pkg::REG_SHORT_THRESHOLD, {8'($urandom), 8'(st)});
    put_reg(tpbd_pkg::REG_MEDIUM_THRESHOLD, {8'($urandom), 8'(mt)});
    put_reg(tpbd_pkg::REG_MAX_BLOCK_BYTES, 16'(lim));
    wr_en <= 1'b0;
    cur_version = ver;
    cur_st = st;
    cur_mt = mt;
  endtask

  task automatic run_phase(int ver, int st, int mt, int lim, int mode, int n_items,
                           bit hold);
    set_config(ver, st, mt, lim);
    case (mode)
      0: begin send_idle = 0;  recv_idle <= 0;  end
      1: begin send_idle = 54; recv_idle <= 0;  end
      2: begin send_idle = 0;  recv_idle <= 54; end
      default: begin send_idle = 24; recv_idle <= 24; end
    endcase
    if (hold) hold_seq <= hold_seq + 1;
    while (block_q.size() < n_items) build_block();
    send_queue();
    drain();
    n_phases++;
  endtask

  initial begin
    int st;
    int mt;
    int lim;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: threshold edges, full byte, flush, long and pause forms,
    // ended block, last byte inside a long pulse
    push_raw(8'h20, 1, 0); push_raw(8'h40, 0, 0); push_raw(8'h35, 0, 0);
    push_raw(8'h36, 0, 0); push_raw(8'h01, 0, 0); push_raw(8'h49, 0, 0);
    push_raw(8'h20, 0, 0); push_raw(8'h40, 0, 0);
    push_raw(8'h40, 0, 0); push_raw(8'hFF, 0, 0);
    push_raw(8'h00, 0, 0); push_raw(8'h00, 0, 0); push_raw(8'h10, 0, 0);
    push_raw(8'h00, 0, 0);
    push_raw(8'h35, 0, 0);
    push_raw(8'h00, 1, 0); push_raw(8'hFF, 0, 0); push_raw(8'hFF, 0, 0);
    push_raw(8'hFF, 0, 0);
    push_raw(8'h00, 1, 1);
    push_raw(8'h01, 1, 0); push_raw(8'h00, 0, 0); push_raw(8'h07, 0, 1);
    push_raw(8'h4A, 1, 1);
    send_queue();
    drain();
    n_phases++;

    // Fixed settings: extremes, crossed thresholds, small and zero limits
    run_phase(0, 54, 74, 16'hFFFF, 1, 180, 0);
    run_phase(1, 54, 74, 16'hFFFF, 0, 180, 1);
    run_phase(2, 0, 255, 3, 2, 180, 0);
    run_phase(3, 255, 0, 16'hFFFF, 3, 180, 0);
    run_phase(1, 20, 200, 0, 1, 40, 0);
    run_phase(2, 40, 60, 1, 2, 150, 1);

    // Random settings
    for (int i = 0; i < 4; i++) begin
      st = $urandom_range(90, 20);
      mt = st + $urandom_range(100, 5);
      if (mt > 255) mt = 255;
      case ($urandom_range(2))
        0: lim = $urandom_range(8, 1);
        1: lim = 16'hFFFF;
        default: lim = $urandom_range(16'hFFFF, 0);
      endcase
      run_phase($urandom_range(3), st, mt, lim, i, 200, i == 0);
    end

    repeat (8) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("Covered %0d input transfers over %0d phases, versions 0 to 3,",
             sb.n_inputs, n_phases);
    $display("  %0d results checked, %0d data bytes, %0d pauses, %0d block ends",
             sb.n_results, sb.n_data, sb.n_pauses, sb.n_ends);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
sv/tpbd_pkg.sv
sv/tpbd_front.sv
sv/tpbd_queue.sv
sv/tpbd_back.sv
sv/tape_pulse_block_decoder_unit.sv
sv/tpbd_check.sv
verif/tape_pulse_block_decoder_unit_test.sv
